FILE: rtl/tlv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the TLV record stream parser.
// No dependencies; compiled first.
package tlv_pkg;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  localparam logic [2:0] KIND_SCALAR  = 3'd0;
  localparam logic [2:0] KIND_STR_HDR = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_TYPE = 2'd1;
  localparam logic [1:0] ERR_TRUNC    = 2'd2;

  localparam logic [2:0] TYPE_FIRST_LEN = 3'd4;
  localparam logic [2:0] TYPE_LAST_OK   = 3'd5;

  typedef enum logic [3:0] {
    PH_HDR = 4'b0001,
    PH_VAL = 4'b0010,
    PH_LEN = 4'b0100,
    PH_PAY = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [12:0] rec_key;
    logic [2:0]  rec_type;
    logic [63:0] rec_value;
    logic [31:0] payload_len;
    logic [7:0]  payload_byte;
    logic [1:0]  error_code;
    logic        last_of_run;
  } res_t;

endpackage

FILE: rtl/tlv_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the TLV parser input bytes and results.
// No dependencies.
interface tlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface tlv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [12:0] rec_key;
  logic [2:0]  rec_type;
  logic [63:0] rec_value;
  logic [31:0] payload_len;
  logic [7:0]  payload_byte;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output kind, output rec_key, output rec_type,
                  output rec_value, output payload_len, output payload_byte,
                  output error_code, output last_of_run, input ready);
  modport sink   (input valid, input kind, input rec_key, input rec_type,
                  input rec_value, input payload_len, input payload_byte,
                  input error_code, input last_of_run, output ready);
endinterface

FILE: rtl/tlv_record_stream_parser.sv
`timescale 1ns / 1ps
// TLV record stream parser top level: byte parser and result queue.
// Depends on tlv_pkg and the channel interfaces in tlv_if.sv.
//
// Parses one byte per clock with no bubbles while in_if.ready is high: each
// byte is decoded in the cycle it is accepted, and its results (none, one,
// or two when a buffer's last byte adds a done or error) are written into
// a 4-entry result queue. Results leave at one per clock while out_if.ready
// is high, so a two-result byte takes two output transfers; in_if.ready
// stays high as long as the queue has two free entries, which holds whenever
// results are drained at one per clock. netord_r is sampled at every byte.
module tlv_record_stream_parser (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  tlv_in_if.sink    in_if,
  tlv_out_if.source out_if
);
  import tlv_pkg::*;

  logic                 netord_r;
  phase_t               phase_r, phase_nxt;
  logic [2:0]           byte_cnt_r, byte_cnt_nxt;
  logic [7:0]           hdr_lo_r, hdr_lo_nxt;
  logic [63:0]          val_r, val_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [12:0]          key_r, key_nxt;
  logic [2:0]           type_r, type_nxt;
  logic                 drop_r, drop_nxt;

  res_t                 q_mem [RQ_DEPTH];
  logic [RQ_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [RQ_CW-1:0]     cnt_r;

  logic                 in_fire, out_fire, last;
  logic [7:0]           b;
  res_t                 r0, r1;
  logic                 v0, v1;
  logic [63:0]          val_acc;
  logic [31:0]          len_acc, rem_dec;
  logic [2:0]           need_m1;
  logic [15:0]          hdr;
  logic [1:0]           push_n;

  assign b        = in_if.in_byte;
  assign last     = in_if.in_last;
  assign in_if.ready = (cnt_r <= RQ_CW'(RQ_DEPTH - 2));
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;

  assign need_m1 = 3'((4'd1 << type_r[1:0]) - 4'd1);
  assign val_acc = netord_r ? {val_r[55:0], b}
                            : (val_r | ({56'd0, b} << {byte_cnt_r, 3'b000}));
  assign len_acc = netord_r ? {val_r[23:0], b}
                            : (val_r[31:0] | ({24'd0, b} << {byte_cnt_r[1:0], 3'b000}));
  assign rem_dec = rem_r - 32'd1;
  assign hdr     = netord_r ? {hdr_lo_r, b} : {b, hdr_lo_r};

  always_comb begin
    phase_nxt    = phase_r;
    byte_cnt_nxt = byte_cnt_r;
    hdr_lo_nxt   = hdr_lo_r;
    val_nxt      = val_r;
    rem_nxt      = rem_r;
    key_nxt      = key_r;
    type_nxt     = type_r;
    drop_nxt     = drop_r;
    r0           = '0;
    r1           = '0;
    v0           = 1'b0;
    v1           = 1'b0;

    if (drop_r) begin
      if (last) begin
        drop_nxt = 1'b0;
      end
    end else begin
      unique case (phase_r)
        PH_VAL: begin
          if (byte_cnt_r == need_m1) begin
            v0 = 1'b1;
            r0.kind = KIND_SCALAR;
            r0.rec_key = key_r;
            r0.rec_type = type_r;
            r0.rec_value = val_acc;
            phase_nxt = PH_HDR;
            if (last) begin
              v1 = 1'b1;
              r1.kind = KIND_DONE;
            end
          end else begin
            byte_cnt_nxt = byte_cnt_r + 3'd1;
            val_nxt = val_acc;
            if (last) begin
              v0 = 1'b1;
              r0.kind = KIND_ERROR;
              r0.error_code = ERR_TRUNC;
              phase_nxt = PH_HDR;
            end
          end
        end
        PH_LEN: begin
          if (byte_cnt_r >= 3'd3) begin
            v0 = 1'b1;
            if (len_acc == 32'd0) begin
              r0.kind = KIND_STR_HDR;
              r0.rec_key = key_r;
              r0.rec_type = type_r;
              phase_nxt = PH_HDR;
              if (last) begin
                v1 = 1'b1;
                r1.kind = KIND_DONE;
              end
            end else if (last) begin
              r0.kind = KIND_ERROR;
              r0.error_code = ERR_TRUNC;
              phase_nxt = PH_HDR;
            end else begin
              r0.kind = KIND_STR_HDR;
              r0.rec_key = key_r;
              r0.rec_type = type_r;
              r0.payload_len = len_acc;
              rem_nxt = len_acc;
              byte_cnt_nxt = 3'd0;
              val_nxt = '0;
              phase_nxt = PH_PAY;
            end
          end else begin
            byte_cnt_nxt = byte_cnt_r + 3'd1;
            val_nxt = {32'd0, len_acc};
            if (last) begin
              v0 = 1'b1;
              r0.kind = KIND_ERROR;
              r0.error_code = ERR_TRUNC;
              phase_nxt = PH_HDR;
            end
          end
        end
        PH_PAY: begin
          v0 = 1'b1;
          r0.kind = KIND_PAYLOAD;
          r0.rec_key = key_r;
          r0.rec_type = type_r;
          r0.payload_byte = b;
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_nxt = PH_HDR;
            if (last) begin
              v1 = 1'b1;
              r1.kind = KIND_DONE;
            end
          end else if (last) begin
            v1 = 1'b1;
            r1.kind = KIND_ERROR;
            r1.error_code = ERR_TRUNC;
            phase_nxt = PH_HDR;
          end
        end
        PH_HDR: begin
          if (byte_cnt_r == 3'd0) begin
            hdr_lo_nxt = b;
            byte_cnt_nxt = 3'd1;
            if (last) begin
              v0 = 1'b1;
              r0.kind = KIND_ERROR;
              r0.error_code = ERR_TRUNC;
              phase_nxt = PH_HDR;
            end
          end else begin
            key_nxt = hdr[15:3];
            type_nxt = hdr[2:0];
            byte_cnt_nxt = 3'd0;
            hdr_lo_nxt = '0;
            val_nxt = '0;
            if (hdr[2:0] > TYPE_LAST_OK) begin
              v0 = 1'b1;
              r0.kind = KIND_ERROR;
              r0.rec_key = hdr[15:3];
              r0.rec_type = hdr[2:0];
              r0.error_code = ERR_BAD_TYPE;
              phase_nxt = PH_HDR;
              drop_nxt = !last;
            end else begin
              phase_nxt = (hdr[2:0] < TYPE_FIRST_LEN) ? PH_VAL : PH_LEN;
              if (last) begin
                v0 = 1'b1;
                r0.kind = KIND_ERROR;
                r0.error_code = ERR_TRUNC;
                phase_nxt = PH_HDR;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_HDR;
        end
      endcase
    end

    // back to header: clear the parse state
    if (phase_nxt == PH_HDR && phase_r != PH_HDR || drop_r && last ||
        phase_r == PH_HDR && phase_nxt == PH_HDR && last) begin
      byte_cnt_nxt = 3'd0;
      hdr_lo_nxt   = '0;
      val_nxt      = '0;
      rem_nxt      = '0;
      key_nxt      = '0;
      type_nxt     = '0;
      phase_nxt    = PH_HDR;
    end
    if (phase_r == PH_HDR && byte_cnt_r != 3'd0 && hdr[2:0] > TYPE_LAST_OK && !drop_r) begin
      key_nxt  = '0;
      type_nxt = '0;
    end

    r0.last_of_run = !v1;
    r1.last_of_run = 1'b1;
  end

  assign push_n = {1'b0, v0} + {1'b0, v1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      netord_r   <= 1'b0;
      phase_r    <= PH_HDR;
      byte_cnt_r <= '0;
      hdr_lo_r   <= '0;
      val_r      <= '0;
      rem_r      <= '0;
      key_r      <= '0;
      type_r     <= '0;
      drop_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        netord_r <= cfg_wdata;
      end
      if (in_fire) begin
        phase_r    <= phase_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        hdr_lo_r   <= hdr_lo_nxt;
        val_r      <= val_nxt;
        rem_r      <= rem_nxt;
        key_r      <= key_nxt;
        type_r     <= type_nxt;
        drop_r     <= drop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && v0) begin
      q_mem[wr_ptr_r] <= r0;
    end
    if (in_fire && v1) begin
      q_mem[wr_ptr_r + RQ_AW'(1)] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + RQ_AW'(push_n);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + RQ_AW'(1);
      end
      cnt_r <= cnt_r + (in_fire ? RQ_CW'(push_n) : RQ_CW'(0)) - RQ_CW'(out_fire);
    end
  end

  assign out_if.valid        = (cnt_r != '0);
  assign out_if.kind         = q_mem[rd_ptr_r].kind;
  assign out_if.rec_key      = q_mem[rd_ptr_r].rec_key;
  assign out_if.rec_type     = q_mem[rd_ptr_r].rec_type;
  assign out_if.rec_value    = q_mem[rd_ptr_r].rec_value;
  assign out_if.payload_len  = q_mem[rd_ptr_r].payload_len;
  assign out_if.payload_byte = q_mem[rd_ptr_r].payload_byte;
  assign out_if.error_code   = q_mem[rd_ptr_r].error_code;
  assign out_if.last_of_run  = q_mem[rd_ptr_r].last_of_run;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && drop_r |-> !v0 && !v1)
    else $error("result produced while dropping");

  a_second_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && v1 |-> v0 && last && (r1.kind == KIND_DONE || r1.kind == KIND_ERROR))
    else $error("second result is not a buffer end");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && v0 |=> out_if.valid)
    else $error("pushed result not presented");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for tlv_record_stream_parser: directed and random byte buffers,
// results checked against a behavioral parser. Depends on tlv_pkg and tlv_if.sv.
module tb_top;
  import tlv_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  tlv_in_if  in_ch ();
  tlv_out_if out_ch ();

  tlv_record_stream_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  int tx_idle = 33;
  int rx_idle = 74;
  int fail_cnt = 0;
  int sent_bytes = 0;

  res_t       pending_res[$];
  logic [7:0] buf_bytes[$];

  // parser state as seen by the scoreboard
  bit          big_endian = 1'b0;
  phase_t      ph         = PH_HDR;
  logic [2:0]  cnt        = '0;
  logic [7:0]  hdr_lo     = '0;
  logic [63:0] acc        = '0;
  logic [31:0] remaining  = '0;
  logic [12:0] cur_key    = '0;
  logic [2:0]  cur_type   = '0;
  bit          dropping   = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle);
  end

  function automatic res_t make_res(logic [2:0] kind, logic [12:0] key, logic [2:0] typ,
                                    logic [63:0] value, logic [31:0] len,
                                    logic [7:0] pbyte, logic [1:0] err);
    res_t r;
    r.kind         = kind;
    r.rec_key      = key;
    r.rec_type     = typ;
    r.rec_value    = value;
    r.payload_len  = len;
    r.payload_byte = pbyte;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  task automatic restart_record;
    ph        = PH_HDR;
    cnt       = '0;
    hdr_lo    = '0;
    acc       = '0;
    remaining = '0;
    cur_key   = '0;
    cur_type  = '0;
  endtask

  // Work out the results caused by one accepted byte.
  task automatic parse_byte(input logic [7:0] b, input bit last);
    res_t        step_q[$];
    res_t        r;
    logic [15:0] h;
    logic [3:0]  need;
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        restart_record();
      end
    end else begin
      case (ph)
        PH_VAL: begin
          need = 4'd1 << cur_type[1:0];
          if (big_endian) acc = {acc[55:0], b};
          else acc = acc | (64'(b) << (8 * cnt));
          if ({1'b0, cnt} + 4'd1 == need) begin
            step_q.push_back(make_res(KIND_SCALAR, cur_key, cur_type, acc, '0, '0, ERR_NONE));
            restart_record();
            if (last) step_q.push_back(make_res(KIND_DONE, '0, '0, '0, '0, '0, ERR_NONE));
          end else begin
            cnt = cnt + 3'd1;
            if (last) begin
              step_q.push_back(make_res(KIND_ERROR, '0, '0, '0, '0, '0, ERR_TRUNC));
              restart_record();
            end
          end
        end
        PH_LEN: begin
          if (big_endian) acc = {32'd0, acc[23:0], b};
          else acc = acc | (64'(b) << (8 * cnt[1:0]));
          if (cnt >= 3'd3) begin
            if (acc[31:0] == 32'd0) begin
              step_q.push_back(make_res(KIND_STR_HDR, cur_key, cur_type, '0, '0, '0, ERR_NONE));
              restart_record();
              if (last) step_q.push_back(make_res(KIND_DONE, '0, '0, '0, '0, '0, ERR_NONE));
            end else if (last) begin
              step_q.push_back(make_res(KIND_ERROR, '0, '0, '0, '0, '0, ERR_TRUNC));
              restart_record();
            end else begin
              step_q.push_back(make_res(KIND_STR_HDR, cur_key, cur_type, '0, acc[31:0], '0,
                                        ERR_NONE));
              remaining = acc[31:0];
              cnt       = '0;
              acc       = '0;
              ph        = PH_PAY;
            end
          end else begin
            cnt = cnt + 3'd1;
            if (last) begin
              step_q.push_back(make_res(KIND_ERROR, '0, '0, '0, '0, '0, ERR_TRUNC));
              restart_record();
            end
          end
        end
        PH_PAY: begin
          step_q.push_back(make_res(KIND_PAYLOAD, cur_key, cur_type, '0, '0, b, ERR_NONE));
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            restart_record();
            if (last) step_q.push_back(make_res(KIND_DONE, '0, '0, '0, '0, '0, ERR_NONE));
          end else if (last) begin
            step_q.push_back(make_res(KIND_ERROR, '0, '0, '0, '0, '0, ERR_TRUNC));
            restart_record();
          end
        end
        default: begin
          if (cnt == 3'd0) begin
            hdr_lo = b;
            cnt    = 3'd1;
            if (last) begin
              step_q.push_back(make_res(KIND_ERROR, '0, '0, '0, '0, '0, ERR_TRUNC));
              restart_record();
            end
          end else begin
            h        = big_endian ? {hdr_lo, b} : {b, hdr_lo};
            cur_key  = h[15:3];
            cur_type = h[2:0];
            cnt      = '0;
            hdr_lo   = '0;
            acc      = '0;
            if (cur_type > TYPE_LAST_OK) begin
              step_q.push_back(make_res(KIND_ERROR, cur_key, cur_type, '0, '0, '0,
                                        ERR_BAD_TYPE));
              restart_record();
              if (!last) dropping = 1'b1;
            end else begin
              if (cur_type < TYPE_FIRST_LEN) ph = PH_VAL;
              else ph = PH_LEN;
              if (last) begin
                step_q.push_back(make_res(KIND_ERROR, '0, '0, '0, '0, '0, ERR_TRUNC));
                restart_record();
              end
            end
          end
        end
      endcase
    end
    foreach (step_q[i]) begin
      r             = step_q[i];
      r.last_of_run = (i == step_q.size() - 1);
      pending_res.push_back(r);
    end
  endtask

  task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (a !== e) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result expected none actual kind %0d key %0h", $time, out_ch.kind,
                 out_ch.rec_key);
        fail_cnt++;
      end else begin
        e = pending_res.pop_front();
        cmp_field("kind", 64'(e.kind), 64'(out_ch.kind));
        cmp_field("rec_key", 64'(e.rec_key), 64'(out_ch.rec_key));
        cmp_field("rec_type", 64'(e.rec_type), 64'(out_ch.rec_type));
        cmp_field("rec_value", e.rec_value, out_ch.rec_value);
        cmp_field("payload_len", 64'(e.payload_len), 64'(out_ch.payload_len));
        cmp_field("payload_byte", 64'(e.payload_byte), 64'(out_ch.payload_byte));
        cmp_field("error_code", 64'(e.error_code), 64'(out_ch.error_code));
        cmp_field("last_of_run", 64'(e.last_of_run), 64'(out_ch.last_of_run));
      end
    end
  end

  task automatic send_req(input logic [7:0] b, input bit last);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    parse_byte(b, last);
    sent_bytes++;
  endtask

  task automatic put_hdr(input logic [12:0] key, input logic [2:0] typ);
    logic [15:0] h;
    h = {key, typ};
    if (big_endian) begin
      buf_bytes.push_back(h[15:8]);
      buf_bytes.push_back(h[7:0]);
    end else begin
      buf_bytes.push_back(h[7:0]);
      buf_bytes.push_back(h[15:8]);
    end
  endtask

  task automatic put_field(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) buf_bytes.push_back(big_endian ? v[8*(n-1-i) +: 8] : v[8*i +: 8]);
  endtask

  // Send the queued bytes; noisy buffers mark last at random.
  task automatic send_buf(input bit noisy);
    foreach (buf_bytes[i])
      send_req(buf_bytes[i], noisy ? ($urandom_range(5) == 0) : (i == buf_bytes.size() - 1));
    buf_bytes.delete();
  endtask

  task automatic drain_results;
    in_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_byte_order(input bit big);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= big;
    @(posedge clk);
    big_endian = big;
    cfg_we    <= 1'b0;
  endtask

  task automatic test_scalar_extremes;
    put_hdr(13'h1fff, 3'd0);
    put_field(64'hff, 1);
    send_buf(1'b0);
  endtask

  task automatic test_zero_length;
    put_hdr(13'h0000, 3'd4);
    put_field(64'd0, 4);
    send_buf(1'b0);
  endtask

  task automatic test_bad_type;
    put_hdr(13'h1fff, 3'd7);
    buf_bytes.push_back(8'h00);
    buf_bytes.push_back(8'h5a);
    send_buf(1'b0);
  endtask

  task automatic test_truncated_header;
    send_req(8'h00, 1'b1);
  endtask

  task automatic test_long_length;
    put_hdr(13'h0000, 3'd5);
    put_field(64'hffff_ffff, 4);
    buf_bytes.push_back(8'h00);
    send_buf(1'b0);
  endtask

  task automatic test_mode_change;
    put_hdr(13'h0aaa, 3'd1);
    foreach (buf_bytes[i]) send_req(buf_bytes[i], 1'b0);
    buf_bytes.delete();
    set_byte_order(1'b1);
    send_req(8'h12, 1'b0);
    send_req(8'h34, 1'b1);
  endtask

  task automatic test_random_traffic(input int tx, input int rx, input bit first_order);
    int          r;
    int          cut;
    int          target;
    logic [2:0]  typ;
    logic [31:0] len;
    logic [63:0] v;
    tx_idle = tx;
    rx_idle = rx;
    for (int half = 0; half < 2; half++) begin
      set_byte_order(half[0] ^ first_order);
      target = sent_bytes + 215;
      while (sent_bytes < target) begin
        repeat ($urandom_range(1, 4)) begin
          typ = 3'($urandom_range(5));
          if ($urandom_range(99) < 6) begin
            put_hdr(13'($urandom_range(8191)), 3'($urandom_range(6, 7)));
          end else begin
            put_hdr(13'($urandom_range(8191)), typ);
            if (typ < TYPE_FIRST_LEN) begin
              v = {$urandom, $urandom};
              case ($urandom_range(7))
                0: v = '0;
                1: v = '1;
                default: ;
              endcase
              put_field(v, 1 << typ);
            end else begin
              len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(6);
              put_field(64'(len), 4);
              repeat (len) buf_bytes.push_back(8'($urandom_range(255)));
            end
          end
        end
        r = $urandom_range(99);
        if (r < 12 && buf_bytes.size() > 1) begin
          cut = $urandom_range(1, buf_bytes.size() - 1);
          while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
        end
        if (r >= 94) begin
          buf_bytes.delete();
          repeat ($urandom_range(1, 12)) buf_bytes.push_back(8'($urandom_range(255)));
        end
        send_buf(r >= 88);
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_byte_order(1'b0);
    test_scalar_extremes();
    test_zero_length();
    test_bad_type();
    test_truncated_header();
    test_long_length();
    test_mode_change();
    test_random_traffic(33, 74, 1'b0);
    test_random_traffic(74, 33, 1'b1);
    test_random_traffic(0, 0, 1'($urandom_range(1)));
    drain_results();
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
rtl/tlv_pkg.sv
rtl/tlv_if.sv
rtl/tlv_record_stream_parser.sv
tb/tb_top.sv
